FILE: rtl/sfs_pkg.sv
package sfs_pkg;

  // store size and derived widths
  localparam int MAX_FRACTIONS = 16;
  localparam int IDX_W         = $clog2(MAX_FRACTIONS);
  localparam int CNT_W         = $clog2(MAX_FRACTIONS + 1);
  localparam int VAL_W         = 16;
  localparam int SWAP_W        = 6;
  localparam int POS_W         = 6;
  localparam int SUM_W         = VAL_W + 1;
  localparam int PROD_W        = 2 * VAL_W;

  localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

  // input word
  typedef struct packed {
    logic [VAL_W-1:0] numerator;
    logic [VAL_W-1:0] denominator;
    logic             final_item;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [VAL_W-1:0]  sorted_numerator;
    logic [VAL_W-1:0]  sorted_denominator;
    logic [SWAP_W-1:0] swap_count;
    logic [POS_W-1:0]  source_position;
    logic              end_of_list;
  } out_word_t;

  // one stored fraction
  typedef struct packed {
    logic [VAL_W-1:0]  num;
    logic [VAL_W-1:0]  den;
    logic [SWAP_W-1:0] swaps;
    logic [POS_W-1:0]  src;
  } entry_t;

  // saturating swap count increment
  function automatic entry_t bump(input entry_t e);
    entry_t r;
    r = e;
    if (e.swaps != SWAP_MAX) begin
      r.swaps = e.swaps + SWAP_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/cantor_order_fraction_sorter_top.sv
// Fraction sorter with per-entry swap counts.
// Input channel in_valid/in_ready/in_word carries one fraction per word; the
// word flagged final_item closes the list. Up to 16 fractions are kept in a
// row of cells; words beyond that are dropped (a dropped final word still
// closes the list). Non-final words are taken one per cycle.
// After the final word the row runs a bubble sort: n-1 passes, each a full
// rotation of the 16 cells. Each compare first registers the cross products
// and then makes the exchange. After the sort, one result word per cycle
// leaves through the output register on out_valid/out_ready/out_word while
// the receiver is ready, end_of_list on the last.
// in_ready is low from the final word until the last result is registered;
// a new list may be loaded while that last result still waits.
// A stalled receiver holds the output register and freezes the row.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result.
module cantor_order_fraction_sorter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfs_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sfs_pkg::out_word_t  out_word
);

  localparam int N     = sfs_pkg::MAX_FRACTIONS;
  localparam int IDX_W = sfs_pkg::IDX_W;
  localparam int CNT_W = sfs_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_MUL  = 5'b00010,
    S_CMP  = 5'b00100,
    S_ROT  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   pass_r, pass_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  sfs_pkg::out_word_t out_word_r;

  sfs_pkg::entry_t    cells [N];
  sfs_pkg::entry_t    shift_in [N];
  sfs_pkg::entry_t    load_entry;
  sfs_pkg::entry_t    head_in;
  sfs_pkg::entry_t    tail_in;
  sfs_pkg::entry_t    winner;
  sfs_pkg::entry_t    loser;

  logic               accept;
  logic               room;
  logic [CNT_W-1:0]   n_after;
  logic [CNT_W-1:0]   cmp_len;
  logic               a_first;
  logic               cmp_step;
  logic               emit_go;
  logic               shift_en;

  assign in_ready  = (state_r == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign room      = (cnt_r < CNT_W'(N));
  assign n_after   = room ? cnt_r + CNT_W'(1) : cnt_r;
  assign cmp_len   = cnt_r - CNT_W'(1) - CNT_W'(pass_r);
  assign cmp_step  = (state_r == S_CMP);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign shift_en  = cmp_step || (state_r == S_ROT) || emit_go;

  // new entry for the next free cell
  always_comb begin
    load_entry.num   = in_word.numerator;
    load_entry.den   = in_word.denominator;
    load_entry.swaps = '0;
    load_entry.src   = sfs_pkg::POS_W'(cnt_r);
  end

  // compare cell 1 against the carried entry in cell 0
  sfs_cmp u_cmp (
    .clk     (clk),
    .mul_en  (state_r == S_MUL),
    .a       (cells[1]),
    .b       (cells[0]),
    .a_first (a_first)
  );

  // exchange: the earlier entry goes to the tail, the other stays in front
  always_comb begin
    if (a_first) begin
      winner = sfs_pkg::bump(cells[1]);
      loser  = sfs_pkg::bump(cells[0]);
    end else begin
      winner = cells[0];
      loser  = cells[1];
    end
    head_in = cmp_step ? loser  : cells[1];
    tail_in = cmp_step ? winner : cells[0];
  end

  // row of cells: on a shift each middle cell takes its right-hand neighbour, head and tail take the exchange outputs
  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == N - 1) begin : g_tail
      assign shift_in[k] = tail_in;
    end else if (k == 0) begin : g_head
      assign shift_in[k] = head_in;
    end else begin : g_mid
      assign shift_in[k] = cells[k+1];
    end

    sfs_cell u_cell (
      .clk        (clk),
      .load_en    (accept && room && (cnt_r[IDX_W-1:0] == IDX_W'(k))),
      .load_entry (load_entry),
      .shift_en   (shift_en),
      .shift_in   (shift_in[k]),
      .entry_r    (cells[k])
    );
  end

  // sequencer: load, sort passes, emit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          cnt_nxt  = n_after;
          pass_nxt = '0;
          step_nxt = '0;
          if (in_word.final_item) begin
            state_nxt = (n_after >= CNT_W'(2)) ? S_MUL : S_EMIT;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        step_nxt  = step_r + IDX_W'(1);
        state_nxt = ((CNT_W'(step_r) + CNT_W'(1)) < cmp_len) ? S_MUL : S_ROT;
      end
      S_ROT: begin
        if (step_r == IDX_W'(N - 1)) begin
          step_nxt = '0;
          pass_nxt = pass_r + IDX_W'(1);
          state_nxt = ((CNT_W'(pass_r) + CNT_W'(2)) == cnt_r) ? S_EMIT : S_MUL;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          step_nxt = step_r + IDX_W'(1);
          if ((CNT_W'(step_r) + CNT_W'(1)) == cnt_r) begin
            cnt_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      pass_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload from the head cell
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_word_r.sorted_numerator   <= cells[0].num;
      out_word_r.sorted_denominator <= cells[0].den;
      out_word_r.swap_count         <= cells[0].swaps;
      out_word_r.source_position    <= cells[0].src;
      out_word_r.end_of_list        <= (CNT_W'(step_r) + CNT_W'(1)) == cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/sfs_cell.sv
module sfs_cell (
  input  logic           clk,
  input  logic           load_en,
  input  sfs_pkg::entry_t load_entry,
  input  logic           shift_en,
  input  sfs_pkg::entry_t shift_in,
  output sfs_pkg::entry_t entry_r
);

  // entry register: direct load from the input side, else take the neighbour
  always_ff @(posedge clk) begin
    if (load_en) begin
      entry_r <= load_entry;
    end else if (shift_en) begin
      entry_r <= shift_in;
    end
  end

endmodule

FILE: rtl/sfs_cmp.sv
module sfs_cmp (
  input  logic            clk,
  input  logic            mul_en,
  input  sfs_pkg::entry_t a,
  input  sfs_pkg::entry_t b,
  output logic            a_first
);

  logic [sfs_pkg::PROD_W-1:0] prod_a_r;
  logic [sfs_pkg::PROD_W-1:0] prod_b_r;
  logic [sfs_pkg::SUM_W-1:0]  sum_a;
  logic [sfs_pkg::SUM_W-1:0]  sum_b;

  // cross products, registered before the decision
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_a_r <= a.num * b.den;
      prod_b_r <= b.num * a.den;
    end
  end

  assign sum_a = sfs_pkg::SUM_W'(a.num) + sfs_pkg::SUM_W'(a.den);
  assign sum_b = sfs_pkg::SUM_W'(b.num) + sfs_pkg::SUM_W'(b.den);

  // ordering rules: equal value, then sum, then numerator by sum parity
  always_comb begin
    if (prod_a_r == prod_b_r) begin
      a_first = a.num < b.num;
    end else if (sum_a != sum_b) begin
      a_first = sum_a < sum_b;
    end else if (!sum_a[0]) begin
      a_first = a.num < b.num;
    end else begin
      a_first = a.num > b.num;
    end
  end

endmodule

FILE: rtl/sfs_checker.sv
module sfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sfs_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input sfs_pkg::out_word_t out_word
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // the final word closes the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_word.final_item |=> !in_ready)
    else $error("input still open after final word");

  // a non-final word keeps the input open
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_word.final_item |=> in_ready)
    else $error("input closed after non-final word");

  // while loading, only the last word of a list may still wait
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_ready |-> out_word.end_of_list)
    else $error("mid-list result pending while loading");

endmodule

bind cantor_order_fraction_sorter_top sfs_checker u_sfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: verif/cantor_order_fraction_sorter_top_test.sv
module cantor_order_fraction_sorter_top_test;

  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         ITEM_TARGET      = 180;
  localparam int         DRAIN_CYCLES     = 400;
  localparam int         REPORT_LIMIT     = 10;
  localparam int         DIRECTED_ROWS    = 22;
  localparam logic [5:0] SWAP_CEILING     = 6'h3f;

  // one fraction as held by the sort predictor
  typedef struct packed {
    logic [15:0] num;
    logic [15:0] den;
    logic [5:0]  swaps;
    logic [5:0]  src;
  } frac_entry_t;

  // directed stimulus row, with a typed-in result for single-fraction lists
  typedef struct packed {
    sfs_pkg::in_word_t  word;
    logic               typed;
    sfs_pkg::out_word_t want;
  } load_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sfs_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sfs_pkg::out_word_t out_word;

  frac_entry_t        held_fracs[$];
  sfs_pkg::out_word_t sorted_due[$];
  int          mismatches    = 0;
  int          lists_closed  = 0;
  int          fracs_stored  = 0;
  int          fracs_dropped = 0;
  int          words_checked = 0;
  int          cycles        = 0;
  bit          steady        = 1'b0;

  // directed rows: lone fractions, a non-transitive tie, then an overfull list
  // holding zero denominators, equal values, equal even and odd sums
  load_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{16'd0,     16'd1,     1'b1}, 1'b1, '{16'd0, 16'd1, 6'd0, 6'd0, 1'b1}},
    '{'{16'd65535, 16'd65535, 1'b1}, 1'b1, '{16'd65535, 16'd65535, 6'd0, 6'd0, 1'b1}},
    '{'{16'd0,     16'd1,     1'b0}, 1'b0, '0},
    '{'{16'd1,     16'd3,     1'b0}, 1'b0, '0},
    '{'{16'd0,     16'd5,     1'b1}, 1'b0, '0},
    '{'{16'd65535, 16'd65535, 1'b0}, 1'b0, '0},
    '{'{16'd65535, 16'd1,     1'b0}, 1'b0, '0},
    '{'{16'd0,     16'd65535, 1'b0}, 1'b0, '0},
    '{'{16'd7,     16'd0,     1'b0}, 1'b0, '0},
    '{'{16'd2,     16'd0,     1'b0}, 1'b0, '0},
    '{'{16'd0,     16'd0,     1'b0}, 1'b0, '0},
    '{'{16'd4,     16'd2,     1'b0}, 1'b0, '0},
    '{'{16'd2,     16'd1,     1'b0}, 1'b0, '0},
    '{'{16'd3,     16'd5,     1'b0}, 1'b0, '0},
    '{'{16'd5,     16'd3,     1'b0}, 1'b0, '0},
    '{'{16'd2,     16'd5,     1'b0}, 1'b0, '0},
    '{'{16'd4,     16'd3,     1'b0}, 1'b0, '0},
    '{'{16'd1,     16'd65535, 1'b0}, 1'b0, '0},
    '{'{16'd32768, 16'd32767, 1'b0}, 1'b0, '0},
    '{'{16'd65534, 16'd1,     1'b0}, 1'b0, '0},
    '{'{16'd1,     16'd1,     1'b0}, 1'b0, '0},
    '{'{16'd12345, 16'd6789,  1'b1}, 1'b0, '0}
  };

  cantor_order_fraction_sorter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // ordering rule: does a belong ahead of b
  function automatic bit precedes(input frac_entry_t a, input frac_entry_t b);
    logic [31:0] cross_a;
    logic [31:0] cross_b;
    logic [16:0] sum_a;
    logic [16:0] sum_b;
    cross_a = a.num * b.den;
    cross_b = b.num * a.den;
    sum_a   = a.num + a.den;
    sum_b   = b.num + b.den;
    if (cross_a == cross_b) begin
      return a.num < b.num;
    end
    if (sum_a != sum_b) begin
      return sum_a < sum_b;
    end
    if (!sum_a[0]) begin
      return a.num < b.num;
    end
    return a.num > b.num;
  endfunction

  // store one fraction; on the closing word bubble sort and queue the sorted list
  task automatic load_fraction(input sfs_pkg::in_word_t w);
    frac_entry_t fresh;
    frac_entry_t tmp;
    int          n;
    if (held_fracs.size() < sfs_pkg::MAX_FRACTIONS) begin
      fresh.num   = w.numerator;
      fresh.den   = w.denominator;
      fresh.swaps = '0;
      fresh.src   = 6'(held_fracs.size());
      held_fracs.push_back(fresh);
      fracs_stored++;
    end else begin
      fracs_dropped++;
    end
    if (w.final_item) begin
      n = held_fracs.size();
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = 0; j + 1 < n - i; j++) begin
          if (precedes(held_fracs[j+1], held_fracs[j])) begin
            tmp             = held_fracs[j];
            held_fracs[j]   = held_fracs[j+1];
            held_fracs[j+1] = tmp;
            if (held_fracs[j].swaps != SWAP_CEILING) begin
              held_fracs[j].swaps++;
            end
            if (held_fracs[j+1].swaps != SWAP_CEILING) begin
              held_fracs[j+1].swaps++;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        sorted_due.push_back(sfs_pkg::out_word_t'{held_fracs[i].num, held_fracs[i].den,
                                                  held_fracs[i].swaps, held_fracs[i].src,
                                                  (i == n - 1)});
      end
      held_fracs.delete();
      lists_closed++;
    end
  endtask

  // offer one word, with random gaps ahead of it, and wait for the handshake
  task automatic send_word(input sfs_pkg::in_word_t w, input logic typed,
                           input sfs_pkg::out_word_t want);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    load_fraction(w);
    if (typed) begin
      sorted_due[sorted_due.size() - 1] = want;
    end
  endtask

  // result side: compare each accepted word with the oldest one due, random stalls
  always @(posedge clk) begin : result_check
    sfs_pkg::out_word_t due;
    bit                 bad;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      bad = 1'b0;
      due = '0;
      if (sorted_due.size() == 0) begin
        bad = 1'b1;
      end else begin
        due = sorted_due.pop_front();
        bad = (out_word.sorted_numerator   != due.sorted_numerator)   ||
              (out_word.sorted_denominator != due.sorted_denominator) ||
              (out_word.swap_count         != due.swap_count)         ||
              (out_word.source_position    != due.source_position)    ||
              (out_word.end_of_list        != due.end_of_list);
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("word %0d: due %0d/%0d swaps %0d src %0d end %0b (queued %0d)",
                   words_checked, due.sorted_numerator, due.sorted_denominator,
                   due.swap_count, due.source_position, due.end_of_list,
                   sorted_due.size());
          $display("          got %0d/%0d swaps %0d src %0d end %0b",
                   out_word.sorted_numerator, out_word.sorted_denominator,
                   out_word.swap_count, out_word.source_position, out_word.end_of_list);
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 19);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    sfs_pkg::in_word_t w;
    int                list_len;
    int                mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
    end

    // random lists, mostly within capacity, some overfull; a calm stretch mid-run
    while (fracs_stored + fracs_dropped < ITEM_TARGET) begin
      list_len = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      for (int k = 0; k < list_len; k++) begin
        mode = $urandom_range(9);
        if (mode < 4) begin
          w.numerator   = 16'($urandom);
          w.denominator = 16'($urandom_range(65535, 1));
        end else if (mode < 9) begin
          w.numerator   = 16'($urandom_range(6));
          w.denominator = 16'($urandom_range(6, 1));
        end else begin
          w.numerator   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
          w.denominator = '0;
        end
        w.final_item = (k == list_len - 1);
        steady = (fracs_stored >= 90) && (fracs_stored < 130);
        send_word(w, 1'b0, '0);
      end
    end
    steady   = 1'b0;
    in_valid <= 1'b0;

    // drain, then give the row time to show any stray word
    while (sorted_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d lists sorted: %0d fractions stored, %0d dropped past capacity",
             lists_closed, fracs_stored, fracs_dropped);
    $display("%0d sorted words checked in %0d cycles", words_checked, cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
